// ===== design/idle_connection_timing_wheel_top_assert.svh =====
// Assertion macros used by the idle connection timing wheel sequencer.
`ifndef IDLE_CONNECTION_TIMING_WHEEL_TOP_ASSERT_SVH
`define IDLE_CONNECTION_TIMING_WHEEL_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ICW_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icw assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ICW_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icw assertion failed");

`endif

// ===== design/icw_pkg.sv =====
// Package with the shared types and constants of the idle connection timing wheel.
package icw_pkg;

   localparam int MAX_CONN    = 64;
   localparam int WHEEL_SLOTS = 8;

   localparam int ID_W   = 6;
   localparam int ACT_W  = 2;
   localparam int IDX_W  = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
   localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;

   localparam logic [ID_W:0]     CONN_LIMIT = (ID_W + 1)'(MAX_CONN);
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(MAX_CONN - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WHEEL_SLOTS - 1);

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD     = 2'd0,
      ACT_REMOVE  = 2'd1,
      ACT_REFRESH = 2'd2,
      ACT_TICK    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_SCAN,
      ST_DRAIN,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic [SLOT_W-1:0] cur_slot;
      logic [SLOT_W-1:0] next_slot;
      logic              due;
   } wheel_status_type;

   typedef struct packed {
      logic            strobe;
      logic [ID_W-1:0] id;
      logic            evicted;
      logic            was_present;
      logic            last;
   } emit_type;

endpackage

// ===== design/icw_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module icw_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 3,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/icw_wheel.sv =====
// Wheel slot pointer and per-slot due flags.
module icw_wheel
   import icw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             tick,
   output wheel_status_type status
);

   logic [SLOT_W-1:0]      cur_ff, cur_in;
   logic [SLOT_W-1:0]      next_slot;
   logic [WHEEL_SLOTS-1:0] flags_ff, flags_in;

   assign next_slot = (cur_ff == LAST_SLOT) ? '0 : cur_ff + 1'b1;

   // On a tick the slot being left becomes due and the slot entered is cleaned.
   always_comb begin
      cur_in   = cur_ff;
      flags_in = flags_ff;
      if (tick) begin
         cur_in              = next_slot;
         flags_in[cur_ff]    = 1'b1;
         flags_in[next_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         flags_ff <= '0;
      end else begin
         cur_ff   <= cur_in;
         flags_ff <= flags_in;
      end
   end

   assign status.cur_slot  = cur_ff;
   assign status.next_slot = next_slot;
   assign status.due       = flags_ff[next_slot];

endmodule

// ===== design/icw_ctrl.sv =====
// Sequencer: command handling, connection valid bits and the eviction scan.
`include "idle_connection_timing_wheel_top_assert.svh"

module icw_ctrl
   import icw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [ID_W-1:0]   req_conn_id,
   output logic              busy,
   input  wheel_status_type  wheel,
   output logic              tick,
   output logic              ram_wr_en,
   output logic [IDX_W-1:0]  ram_wr_addr,
   output logic [SLOT_W-1:0] ram_wr_data,
   output logic              ram_rd_en,
   output logic [IDX_W-1:0]  ram_rd_addr,
   input  logic [SLOT_W-1:0] ram_rd_data,
   output emit_type          emit
);

   ctrl_state_type state_ff, state_in;

   action_type        act_ff, act_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              cap_live_ff, cap_live_in;
   logic              cap_valid_ff, cap_valid_in;
   logic [IDX_W-1:0]  cap_id_ff, cap_id_in;
   logic              hold_v_ff, hold_v_in;
   logic [IDX_W-1:0]  hold_id_ff, hold_id_in;
   logic [MAX_CONN-1:0] valid_ff, valid_in;

   logic             accept;
   logic             in_range;
   logic [IDX_W-1:0] cmd_idx;
   logic             present;
   logic             hit;

   assign accept   = start && (state_ff == ST_IDLE);
   assign in_range = ({1'b0, id_ff} < CONN_LIMIT);
   assign cmd_idx  = id_ff[IDX_W-1:0];
   assign present  = in_range && valid_ff[cmd_idx];
   // The shared slot comparator: one connection entry per cycle.
   assign hit      = cap_live_ff && cap_valid_ff && (ram_rd_data == slot_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (action_type'(req_action) == ACT_TICK) begin
                  state_in = wheel.due ? ST_SCAN : ST_FLUSH;
               end else begin
                  state_in = ST_CMD;
               end
            end
         end
         ST_CMD:   state_in = ST_IDLE;
         ST_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FLUSH;
         ST_FLUSH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs toward the handshake, the wheel, the slot memory and the result register.
   always_comb begin
      busy        = (state_ff != ST_IDLE);
      tick        = accept && (action_type'(req_action) == ACT_TICK);
      ram_wr_en   = (state_ff == ST_CMD) && in_range && (act_ff != ACT_REMOVE);
      ram_wr_addr = cmd_idx;
      ram_wr_data = wheel.cur_slot;
      ram_rd_en   = (state_ff == ST_SCAN);
      ram_rd_addr = idx_ff;

      emit             = '0;
      emit.id          = id_ff;
      if (state_ff == ST_CMD) begin
         emit.strobe      = 1'b1;
         emit.was_present = present;
         emit.last        = 1'b1;
      end else if (state_ff == ST_FLUSH) begin
         emit.strobe  = hold_v_ff;
         emit.id      = ID_W'(hold_id_ff);
         emit.evicted = 1'b1;
         emit.last    = 1'b1;
      end else if (hit) begin
         // A newer eviction is found, so the held one is not the final result.
         emit.strobe  = hold_v_ff;
         emit.id      = ID_W'(hold_id_ff);
         emit.evicted = 1'b1;
      end
   end

   // Datapath next values.
   always_comb begin
      act_in       = act_ff;
      id_in        = id_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      cap_valid_in = cap_valid_ff;
      cap_id_in    = cap_id_ff;
      hold_v_in    = hold_v_ff;
      hold_id_in   = hold_id_ff;
      valid_in     = valid_ff;
      cap_live_in  = (state_ff == ST_SCAN);

      if (accept) begin
         act_in    = action_type'(req_action);
         id_in     = req_conn_id;
         slot_in   = wheel.next_slot;
         idx_in    = '0;
         hold_v_in = 1'b0;
      end

      if (state_ff == ST_CMD && in_range) begin
         valid_in[cmd_idx] = (act_ff != ACT_REMOVE);
      end

      if (state_ff == ST_SCAN) begin
         idx_in       = idx_ff + 1'b1;
         cap_valid_in = valid_ff[idx_ff];
         cap_id_in    = idx_ff;
      end

      if (hit) begin
         valid_in[cap_id_ff] = 1'b0;
         hold_v_in           = 1'b1;
         hold_id_in          = cap_id_ff;
      end

      if (state_ff == ST_FLUSH) begin
         hold_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         cap_live_ff <= 1'b0;
         hold_v_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         cap_live_ff <= cap_live_in;
         hold_v_ff   <= hold_v_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      id_ff        <= id_in;
      slot_ff      <= slot_in;
      idx_ff       <= idx_in;
      cap_valid_ff <= cap_valid_in;
      cap_id_ff    <= cap_id_in;
      hold_id_ff   <= hold_id_in;
   end

   `ICW_ASSERT_NOW(a_no_emit_idle, clock, reset, state_ff == ST_IDLE, !emit.strobe)
   `ICW_ASSERT_NEXT(a_flush_empties, clock, reset, state_ff == ST_FLUSH, !hold_v_ff)
   `ICW_ASSERT_NEXT(a_due_tick_scans, clock, reset, tick && wheel.due, state_ff == ST_SCAN)
   `ICW_ASSERT_NOW(a_scan_not_last, clock, reset, emit.strobe && (state_ff == ST_SCAN || state_ff == ST_DRAIN), !emit.last && emit.evicted)

endmodule

// ===== design/idle_connection_timing_wheel_top.sv =====
// Top level of the idle connection timing wheel.
// An item is taken when start is high and busy is low. For add, remove and
// refresh the item is taken, then the command state updates the connection's
// valid bit (and, for add and refresh, its slot entry) and registers its single
// result onto the rsp_ ports. A tick whose entered slot is not due goes through
// the flush state and gives no result; when it is due, the sequencer walks the
// connection table one entry per cycle through the slot memory's single read
// port and one shared slot comparator, and busy stays high through the walk.
// Evictions come out in ascending id order while the walk goes on; each one is
// held back until the next is found, so the one that carries last comes out at
// the end of the walk. A due tick with nothing to evict gives no result. Every
// result is shown for exactly one cycle, marked by rsp_strobe, and the receiver
// cannot stall it. Reset needs no clearing pass: connection valid bits and slot
// flags are flip-flops cleared at once.
module idle_connection_timing_wheel_top
   import icw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [ACT_W-1:0] req_action,
   input  logic [ID_W-1:0]  req_conn_id,
   output logic             rsp_strobe,
   output logic [ID_W-1:0]  rsp_result_id,
   output logic             rsp_evicted,
   output logic             rsp_was_present,
   output logic             rsp_last
);

   wheel_status_type  wheel;
   logic              tick;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [SLOT_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [SLOT_W-1:0] ram_rd_data;
   emit_type          emit;

   // The result register: the strobe is cleared by reset, the fields are not.
   logic            rsp_strobe_ff;
   logic [ID_W-1:0] rsp_id_ff;
   logic            rsp_evicted_ff;
   logic            rsp_was_present_ff;
   logic            rsp_last_ff;

   icw_wheel u_wheel (
      .clock  (clock),
      .reset  (reset),
      .tick   (tick),
      .status (wheel)
   );

   // Slot of each connection's last activity; the scan reads every entry and uses it only while its valid bit is set.
   icw_ram #(
      .DEPTH (MAX_CONN),
      .WIDTH (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   icw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_action  (req_action),
      .req_conn_id (req_conn_id),
      .busy        (busy),
      .wheel       (wheel),
      .tick        (tick),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .emit        (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= emit.strobe;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_ff          <= emit.id;
      rsp_evicted_ff     <= emit.evicted;
      rsp_was_present_ff <= emit.was_present;
      rsp_last_ff        <= emit.last;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_id   = rsp_id_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_was_present = rsp_was_present_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== verif/idle_connection_timing_wheel_top_tb.sv =====
// Self-checking testbench for the idle connection timing wheel top level.
module idle_connection_timing_wheel_top_tb;
   import icw_pkg::*;

   // One command sent to the wheel, and one response it should answer.
   typedef struct {
      action_type      act;
      logic [ID_W-1:0] id;
   } wheel_cmd_type;

   typedef struct {
      logic [ID_W-1:0] id;
      logic            evicted;
      logic            was_present;
      logic            last;
   } wheel_rsp_type;

   // The longest busy stretch is a due tick's walk of the whole table. The
   // drain wait at the end and the hang limit are both set well beyond that.
   localparam int DRAIN_CYCLES  = MAX_CONN + 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 220;
   localparam int QUIET_TAIL    = 25;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [ACT_W-1:0] req_action = ACT_ADD;
   logic [ID_W-1:0]  req_conn_id = '0;
   logic             rsp_strobe;
   logic [ID_W-1:0]  rsp_result_id;
   logic             rsp_evicted;
   logic             rsp_was_present;
   logic             rsp_last;

   idle_connection_timing_wheel_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_conn_id     (req_conn_id),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_id   (rsp_result_id),
      .rsp_evicted     (rsp_evicted),
      .rsp_was_present (rsp_was_present),
      .rsp_last        (rsp_last)
   );

   // Period of 8 time units.
   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // Commands waiting to be sent, and responses the wheel still owes us.
   wheel_cmd_type cmd_queue[$];
   wheel_rsp_type owed_rsps[$];

   int  mismatches = 0;
   int  cycles = 0;
   int  sent_count = 0;
   int  gap_left = 0;
   logic taken_q = 1'b0;

   // Our own copy of the wheel: which ids are tracked, the slot each one was
   // last active in, the slot pointer, and which slots have been passed by a
   // tick and are therefore due for eviction when the pointer comes back.
   bit                conn_live [MAX_CONN];
   logic [SLOT_W-1:0] conn_home [MAX_CONN];
   bit                slot_due  [WHEEL_SLOTS];
   logic [SLOT_W-1:0] wheel_pos = '0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("MISMATCH at cycle %0d: %s", cycles, msg);
      end
   endtask

   // Work out what one accepted item does to the wheel and which responses it
   // must produce, and queue those responses in order.
   task automatic predict_wheel_rsps(input action_type act, input logic [ID_W-1:0] id);
      wheel_rsp_type r;
      int            evictions;
      bit            present;
      evictions = 0;
      present = 1'b0;
      if (act == ACT_TICK) begin
         // The slot we leave becomes due; entering a due slot evicts everything
         // still recorded there, lowest id first, with last on the final one.
         slot_due[wheel_pos] = 1'b1;
         wheel_pos = (wheel_pos == LAST_SLOT) ? '0 : wheel_pos + 1'b1;
         if (slot_due[wheel_pos]) begin
            for (int i = 0; i < MAX_CONN; i++) begin
               if (conn_live[i] && conn_home[i] == wheel_pos) begin
                  conn_live[i] = 1'b0;
                  r.id = ID_W'(i);
                  r.evicted = 1'b1;
                  r.was_present = 1'b0;
                  r.last = 1'b0;
                  owed_rsps.push_back(r);
                  evictions++;
               end
            end
            if (evictions > 0) begin
               owed_rsps[owed_rsps.size() - 1].last = 1'b1;
            end
         end
         slot_due[wheel_pos] = 1'b0;
      end else begin
         // Add and refresh both (re)home the id in the current slot, so an add
         // of a tracked id is a refresh and a refresh of an unknown id is an
         // add. Removing an unknown id changes nothing.
         if (int'(id) < MAX_CONN) begin
            present = conn_live[id];
            if (act == ACT_REMOVE) begin
               conn_live[id] = 1'b0;
            end else begin
               conn_live[id] = 1'b1;
               conn_home[id] = wheel_pos;
            end
         end
         r.id = id;
         r.evicted = 1'b0;
         r.was_present = present;
         r.last = 1'b1;
         owed_rsps.push_back(r);
      end
   endtask

   task automatic queue_cmd(input action_type act, input logic [ID_W-1:0] id);
      wheel_cmd_type c;
      c.act = act;
      c.id = id;
      cmd_queue.push_back(c);
   endtask

   // Driver. Inputs move on the falling edge. A command stays on the ports
   // with start high until the monitor has seen it taken; after that the
   // driver may pause with start low before the next command. Every third
   // stretch of 30 items runs without gaps, and so does the final stretch.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !taken_q)) begin
         if (start) begin
            void'(cmd_queue.pop_front());
            sent_count++;
            if (cmd_queue.size() > QUIET_TAIL && (sent_count / 30) % 3 != 1 &&
                $urandom_range(0, 3) == 0) begin
               gap_left = $urandom_range(1, 16);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            start <= 1'b1;
            req_action <= cmd_queue[0].act;
            req_conn_id <= cmd_queue[0].id;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. Everything is sampled on the rising edge. A response is checked
   // against the oldest owed one before the item taken on the same edge is
   // predicted, so a stray response can never match its own prediction.
   always @(posedge clock) begin
      wheel_rsp_type want;
      if (reset) begin
         taken_q <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (owed_rsps.size() == 0) begin
               report_mismatch($sformatf(
                  "unexpected response id=%0d evicted=%0b was_present=%0b last=%0b",
                  rsp_result_id, rsp_evicted, rsp_was_present, rsp_last));
            end else begin
               want = owed_rsps.pop_front();
               if (rsp_result_id !== want.id || rsp_evicted !== want.evicted ||
                   rsp_was_present !== want.was_present || rsp_last !== want.last) begin
                  report_mismatch({
                     $sformatf("expected id=%0d evicted=%0b was_present=%0b last=%0b",
                               want.id, want.evicted, want.was_present, want.last),
                     $sformatf(", got id=%0d evicted=%0b was_present=%0b last=%0b",
                               rsp_result_id, rsp_evicted, rsp_was_present, rsp_last)});
               end
            end
         end
         if (start && !busy) begin
            predict_wheel_rsps(action_type'(req_action), req_conn_id);
         end
         taken_q <= start && !busy;
      end
   end

   // Hang guard.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int              made;
      int              kind;
      int              pick;
      int              burst;
      logic [ID_W-1:0] rid;

      // Directed part: both id extremes, every action, and the special cases:
      // add of a tracked id, refresh of an unknown id, remove of an unknown id,
      // ticks that evict nothing, and a full lap of the wheel that evicts the
      // ids still homed in slot 0.
      queue_cmd(ACT_ADD, 6'd0);
      queue_cmd(ACT_ADD, 6'd63);
      queue_cmd(ACT_ADD, 6'd0);
      queue_cmd(ACT_REFRESH, 6'd5);
      queue_cmd(ACT_REFRESH, 6'd63);
      queue_cmd(ACT_REMOVE, 6'd7);
      queue_cmd(ACT_REMOVE, 6'd63);
      for (int i = 0; i < WHEEL_SLOTS; i++) begin
         queue_cmd(ACT_TICK, ID_W'($urandom_range(0, 63)));
      end
      queue_cmd(ACT_ADD, 6'd42);
      queue_cmd(ACT_TICK, 6'd63);
      queue_cmd(ACT_REMOVE, 6'd42);
      queue_cmd(ACT_REFRESH, 6'd0);

      // Random part. It opens by filling the whole table and letting it all
      // time out, which gives the longest run of evictions from one tick.
      // After that come bursts of adds that are left to expire and single
      // items of every kind, with ids often drawn from a small pool so that
      // refresh, remove and re-add hit tracked connections.
      made = 0;
      for (int i = MAX_CONN - 1; i >= 0; i--) begin
         queue_cmd(ACT_ADD, ID_W'(i));
         made++;
      end
      for (int i = 0; i < WHEEL_SLOTS; i++) begin
         queue_cmd(ACT_TICK, ID_W'($urandom_range(0, 63)));
         made++;
      end
      while (made < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind >= 7) begin
            burst = $urandom_range(3, 12);
            for (int i = 0; i < burst; i++) begin
               queue_cmd(ACT_ADD, ID_W'($urandom_range(0, 63)));
            end
            for (int i = 0; i < WHEEL_SLOTS; i++) begin
               queue_cmd(ACT_TICK, ID_W'($urandom_range(0, 63)));
            end
            made += burst + WHEEL_SLOTS;
         end else begin
            rid = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 15))
                                       : ID_W'($urandom_range(0, 63));
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
               queue_cmd(ACT_ADD, rid);
            end else if (pick <= 5) begin
               queue_cmd(ACT_REFRESH, rid);
            end else if (pick <= 7) begin
               queue_cmd(ACT_REMOVE, rid);
            end else begin
               queue_cmd(ACT_TICK, rid);
            end
            made++;
         end
      end

      // Synchronous reset, held from time zero and released on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every command is taken and every owed response is back,
      // then give a trailing tick time to finish its table walk.
      while (cmd_queue.size() > 0 || start || owed_rsps.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      while (owed_rsps.size() > 0) begin
         wheel_rsp_type left;
         left = owed_rsps.pop_front();
         report_mismatch($sformatf(
            "missing response id=%0d evicted=%0b was_present=%0b last=%0b",
            left.id, left.evicted, left.was_present, left.last));
      end

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/icw_pkg.sv
design/icw_ram.sv
design/icw_wheel.sv
design/icw_ctrl.sv
design/idle_connection_timing_wheel_top.sv
verif/idle_connection_timing_wheel_top_tb.sv
